[hw/rtl/pfd_pkg.sv]
package pfd_pkg;

  localparam int PAYLOAD_BYTES = 24;
  localparam int IDX_W = 5;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HEAD_FIRST  = 3'd0;
  localparam logic [2:0] REG_HEAD_SECOND = 3'd1;
  localparam logic [2:0] REG_TAIL_FIRST  = 3'd2;
  localparam logic [2:0] REG_TAIL_SECOND = 3'd3;
  localparam logic [2:0] REG_FRAME_IDENT = 3'd4;
  localparam logic [2:0] REG_LENGTH_CODE = 3'd5;

  localparam logic [7:0] FRAME_IDENT_RST = 8'h01;
  localparam logic [7:0] LENGTH_CODE_RST = 8'h18;

  // operations handed from front to back
  localparam logic [1:0] OP_PAY    = 2'd0;
  localparam logic [1:0] OP_CHK_LO = 2'd1;
  localparam logic [1:0] OP_CHK_HI = 2'd2;
  localparam logic [1:0] OP_EMIT   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_x;
    logic [31:0] word_y;
    logic [31:0] word_yaw;
    logic [31:0] word_yaw_rate;
    logic [31:0] word_speed;
    logic [31:0] word_extra;
    logic [15:0] check_word;
  } out_item_t;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
    logic [7:0] frame_ident;
    logic [7:0] length_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } op_t;

endpackage

[hw/rtl/pfd_front.sv]
module pfd_front
  import pfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output op_t      push_op
);

  localparam logic [3:0] PH_HEAD1   = 4'd0;
  localparam logic [3:0] PH_HEAD2   = 4'd1;
  localparam logic [3:0] PH_IDENT   = 4'd2;
  localparam logic [3:0] PH_LENGTH  = 4'd3;
  localparam logic [3:0] PH_PAYLOAD = 4'd4;
  localparam logic [3:0] PH_CHECK   = 4'd5;
  localparam logic [3:0] PH_TAIL1   = 4'd6;
  localparam logic [3:0] PH_TAIL2   = 4'd7;
  localparam logic [3:0] PH_IGNORE  = 4'd8;

  localparam logic [IDX_W-1:0] PAY_LAST = IDX_W'(PAYLOAD_BYTES - 1);

  logic [3:0]       phase, phase_next;
  logic [IDX_W-1:0] byte_count, byte_count_next;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    push            = 1'b0;
    push_op.kind    = OP_PAY;
    push_op.idx     = byte_count;
    push_op.data    = b;
    if (accept) begin
      case (phase)
        PH_HEAD1:  phase_next = (b == cfg.head_first)  ? PH_HEAD2  : PH_HEAD1;
        PH_HEAD2:  phase_next = (b == cfg.head_second) ? PH_IDENT  : PH_HEAD1;
        PH_IDENT:  phase_next = (b == cfg.frame_ident) ? PH_LENGTH : PH_HEAD1;
        PH_LENGTH: begin
          phase_next      = (b == cfg.length_code) ? PH_PAYLOAD : PH_HEAD1;
          byte_count_next = '0;
        end
        PH_PAYLOAD: begin
          push = 1'b1;
          if (byte_count == PAY_LAST) begin
            byte_count_next = '0;
            phase_next      = PH_CHECK;
          end else begin
            byte_count_next = byte_count + 1'b1;
          end
        end
        PH_CHECK: begin
          push = 1'b1;
          if (byte_count == '0) begin
            push_op.kind    = OP_CHK_LO;
            byte_count_next = IDX_W'(1);
          end else begin
            push_op.kind    = OP_CHK_HI;
            byte_count_next = '0;
            phase_next      = PH_TAIL1;
          end
        end
        PH_TAIL1: phase_next = (b == cfg.tail_first) ? PH_TAIL2 : PH_HEAD1;
        PH_TAIL2: begin
          push         = (b == cfg.tail_second);
          push_op.kind = OP_EMIT;
          phase_next   = PH_IGNORE;
        end
        PH_IGNORE: phase_next = PH_IGNORE;
        default: begin
          phase_next      = PH_HEAD1;
          byte_count_next = '0;
        end
      endcase
      if (item.last_in_buffer) begin
        phase_next      = PH_HEAD1;
        byte_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD1;
      byte_count <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

[hw/rtl/pfd_queue.sv]
module pfd_queue
  import pfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic head_valid,
  output op_t  head_op,
  input  logic pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/pfd_back.sv]
module pfd_back
  import pfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  op_t       head_op,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [7:0]  pay [PAYLOAD_BYTES];
  logic [15:0] chk;
  logic        is_emit;

  assign is_emit = (head_op.kind == OP_EMIT);
  // an emit waits only while the output register is still held
  assign pop = head_valid && (!is_emit || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head_op.kind)
        OP_PAY:    pay[head_op.idx] <= head_op.data;
        OP_CHK_LO: chk[7:0]         <= head_op.data;
        OP_CHK_HI: chk[15:8]        <= head_op.data;
        OP_EMIT: begin
          out_item.word_x        <= {pay[3],  pay[2],  pay[1],  pay[0]};
          out_item.word_y        <= {pay[7],  pay[6],  pay[5],  pay[4]};
          out_item.word_yaw      <= {pay[11], pay[10], pay[9],  pay[8]};
          out_item.word_yaw_rate <= {pay[15], pay[14], pay[13], pay[12]};
          out_item.word_speed    <= {pay[19], pay[18], pay[17], pay[16]};
          out_item.word_extra    <= {pay[23], pay[22], pay[21], pay[20]};
          out_item.check_word    <= chk;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/position_frame_deframer.sv]
// frame_valid rises once the emit op for the accepted second tail byte leaves
//   the queue for the output register; older queued ops or an output stall delay it.
// Throughput: one byte per cycle; byte_stall rises only when the front/back
//   queue is full, which happens while a finished frame waits at the output.
// Reset (rst, synchronous): parser hunts for the first header, queue empty,
//   no frame pending; registers return to their defaults (ident 0x01, length 0x18).
module position_frame_deframer
  import pfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // received bytes
  input  logic        byte_valid,
  output logic        byte_stall,
  input  in_item_t    byte_item,
  // decoded frames
  output logic        frame_valid,
  input  logic        frame_stall,
  output out_item_t   frame_item,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        accept;
  logic        push;
  op_t         push_op;
  logic        q_full;
  logic        head_valid;
  op_t         head_op;
  logic        pop;

  // ---------------------------------------------------------------
  // Register file. Writes land on the access phase; index six and
  // seven decode to nothing and are dropped.
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_first  <= '0;
      cfg.head_second <= '0;
      cfg.tail_first  <= '0;
      cfg.tail_second <= '0;
      cfg.frame_ident <= FRAME_IDENT_RST;
      cfg.length_code <= LENGTH_CODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEAD_FIRST:  cfg.head_first  <= pwdata[7:0];
        REG_HEAD_SECOND: cfg.head_second <= pwdata[7:0];
        REG_TAIL_FIRST:  cfg.tail_first  <= pwdata[7:0];
        REG_TAIL_SECOND: cfg.tail_second <= pwdata[7:0];
        REG_FRAME_IDENT: cfg.frame_ident <= pwdata[7:0];
        REG_LENGTH_CODE: cfg.length_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD_FIRST:  prdata = {24'd0, cfg.head_first};
      REG_HEAD_SECOND: prdata = {24'd0, cfg.head_second};
      REG_TAIL_FIRST:  prdata = {24'd0, cfg.tail_first};
      REG_TAIL_SECOND: prdata = {24'd0, cfg.tail_second};
      REG_FRAME_IDENT: prdata = {24'd0, cfg.frame_ident};
      REG_LENGTH_CODE: prdata = {24'd0, cfg.length_code};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Front: header/ident/length/tail matching, one byte per cycle when not stalled.
  // It only emits ops for bytes that change back-end state, so
  // header hunting never touches the queue.
  // ---------------------------------------------------------------
  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;

  pfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .item    (byte_item),
    .push    (push),
    .push_op (push_op)
  );

  // queue decouples the byte side from a stalled frame consumer
  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  // ---------------------------------------------------------------
  // Back: payload/check storage and the output register. A frame is
  // snapshotted on the emit op, so the next frame's bytes may refill
  // storage while the result still waits.
  // ---------------------------------------------------------------
  pfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (frame_valid),
    .out_stall  (frame_stall),
    .out_item   (frame_item)
  );

endmodule

[hw/rtl/pfd_checker.sv]
module pfd_checker
  import pfd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input logic      frame_valid,
  input logic      frame_stall,
  input out_item_t frame_item
);

  // a held frame stays put
  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid && $stable(frame_item))
    else $error("frame item changed while stalled");

  // reset leaves nothing pending and the byte side open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !frame_valid && !byte_stall)
    else $error("state not cleared by reset");

  // queue can only fill from an accepted byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(byte_stall) |-> $past(byte_valid))
    else $error("byte_stall rose without a byte offered");

  // a frame leaves only when taken
  a_frame_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(frame_valid) |-> $past(!frame_stall))
    else $error("frame dropped while stalled");

endmodule

bind position_frame_deframer pfd_checker u_pfd_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .frame_valid (frame_valid),
  .frame_stall (frame_stall),
  .frame_item  (frame_item)
);
